>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lct_pkg.sv
package lct_pkg;

    // Milliseconds per second and the width of a timing threshold in ms.
    localparam int unsigned MS_PER_S = 1000;
    localparam int unsigned MS_W     = 27;

    localparam logic [31:0] NO_LIMIT = 32'hFFFF_FFFF;

    // Phase codes.
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_PRE   = 3'd1;
    localparam logic [2:0] PH_SET   = 3'd2;
    localparam logic [2:0] PH_ON    = 3'd3;
    localparam logic [2:0] PH_RESET = 3'd4;
    localparam logic [2:0] PH_COUNT = 3'd5;
    localparam logic [2:0] PH_OFF   = 3'd6;

    // Input word kinds.
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_RUN  = 2'd1;
    localparam logic [1:0] KIND_STOP = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_START_DELAY = 3'd0;
    localparam logic [2:0] CFG_ON_TIME     = 3'd1;
    localparam logic [2:0] CFG_OFF_TIME    = 3'd2;
    localparam logic [2:0] CFG_CHARGE_LIM  = 3'd3;
    localparam logic [2:0] CFG_REPEAT      = 3'd4;

    // Channel state.
    typedef struct packed {
        logic [2:0]  phase;
        logic [31:0] phase_stamp;
        logic [31:0] on_stamp;
        logic [31:0] off_stamp;
        logic [15:0] remaining;
        logic [31:0] on_total;
        logic        drive;
        logic        stopping;
    } chan_state_t;

    // Configuration, with the timings already scaled to milliseconds.
    typedef struct packed {
        logic [MS_W-1:0] start_ms;
        logic [MS_W-1:0] on_ms;
        logic [MS_W-1:0] off_ms;
        logic [31:0]     charge_limit;
        logic [15:0]     repeat_count;
    } chan_cfg_t;

endpackage

>>> rtl/lct_step.sv
module lct_step
    import lct_pkg::*;
(
    input  logic [1:0]  kind,
    input  logic [31:0] now_ms,
    input  logic [31:0] charge_used,
    input  chan_state_t cur,
    input  chan_cfg_t   cfg,
    output chan_state_t nxt,
    output logic        refused
);

    logic [MS_W-1:0] sd_ms;
    logic [MS_W-1:0] on_ms;
    logic [MS_W-1:0] off_ms;
    logic [31:0]     lim;
    logic [31:0]     elapsed;
    logic            over_charge;
    logic            on_done;
    logic [31:0]     off_point;
    logic [31:0]     on_span;
    logic [15:0]     rem_dec;

    // A stop in progress forces one-second timings and no charge limit.
    assign sd_ms  = cur.stopping ? MS_W'(MS_PER_S) : cfg.start_ms;
    assign on_ms  = cur.stopping ? MS_W'(MS_PER_S) : cfg.on_ms;
    assign off_ms = cur.stopping ? MS_W'(MS_PER_S) : cfg.off_ms;
    assign lim    = cur.stopping ? NO_LIMIT : cfg.charge_limit;

    // Shared time and charge comparisons.
    assign elapsed     = now_ms - cur.phase_stamp;
    assign over_charge = charge_used > lim;
    assign on_done     = elapsed >= 32'(on_ms);

    // The turn-off step either uses the stored off stamp or, when it follows
    // the on phase in the same tick, the current time.
    assign off_point = (cur.phase == PH_ON) ? now_ms : cur.off_stamp;
    assign on_span   = off_point - cur.on_stamp;
    assign rem_dec   = (cur.remaining != 16'd0) ? cur.remaining - 16'd1 : 16'd0;

    // Next state for one word.
    always_comb
    begin
        nxt     = cur;
        refused = 1'b0;
        case (kind)
            KIND_TICK:
            begin
                case (cur.phase)
                    PH_PRE:
                    begin
                        if (elapsed > 32'(sd_ms))
                        begin
                            nxt.phase = PH_SET;
                        end
                    end
                    PH_SET:
                    begin
                        nxt.drive       = 1'b1;
                        nxt.phase_stamp = now_ms;
                        nxt.on_stamp    = now_ms;
                        nxt.phase       = PH_ON;
                    end
                    PH_ON:
                    begin
                        if (over_charge)
                        begin
                            nxt.off_stamp = now_ms;
                            nxt.phase     = PH_RESET;
                            nxt.remaining = 16'd0;
                        end
                        else if (on_done)
                        begin
                            nxt.off_stamp   = now_ms;
                            nxt.drive       = 1'b0;
                            nxt.on_total    = cur.on_total + on_span;
                            nxt.phase_stamp = now_ms;
                            nxt.phase       = PH_COUNT;
                        end
                    end
                    PH_RESET:
                    begin
                        nxt.drive       = 1'b0;
                        nxt.on_total    = cur.on_total + on_span;
                        nxt.phase_stamp = now_ms;
                        nxt.phase       = PH_COUNT;
                    end
                    PH_COUNT:
                    begin
                        nxt.remaining = rem_dec;
                        if (rem_dec != 16'd0)
                        begin
                            nxt.phase = PH_OFF;
                        end
                        else
                        begin
                            nxt.phase_stamp = 32'd0;
                            nxt.stopping    = 1'b0;
                            nxt.phase       = PH_IDLE;
                        end
                    end
                    PH_OFF:
                    begin
                        if (elapsed > 32'(off_ms))
                        begin
                            nxt.phase = PH_SET;
                        end
                    end
                    default:
                    begin
                        nxt = cur;
                    end
                endcase
            end
            KIND_RUN:
            begin
                if (cur.phase != PH_IDLE)
                begin
                    refused = 1'b1;
                end
                else
                begin
                    nxt.phase       = PH_PRE;
                    nxt.remaining   = cfg.repeat_count;
                    nxt.on_total    = 32'd0;
                    nxt.phase_stamp = now_ms;
                end
            end
            KIND_STOP:
            begin
                if (cur.phase != PH_IDLE)
                begin
                    nxt.stopping  = 1'b1;
                    nxt.remaining = 16'd1;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

>>> rtl/led_cycle_timer_core.sv
// LED cycle timer, one channel; instantiate one per LED string.
// Input stream (s_axis): each word is a millisecond tick, a run command or a
// stop command, selected by tuser, with the current time and charge reading
// in tdata. Every accepted word yields exactly one result word on m_axis
// carrying the LED drive, phase, cycles left, on-time total and a refused
// flag for a run that arrived while the channel was active.
// Configuration: cfg_we writes cfg_data to register cfg_index;
// write only while the channel has no word in flight. Timings are scaled to
// milliseconds as they are written.
// Datapath: an accepted word is held in the input register, then the state
// update and result are captured together in the output register. Throughput
// is one word per clock while the receiver takes results; the state update is
// a combinational compare and add, so a word may follow every cycle.
// Reset clears the channel to idle with all stamps and totals at zero and
// restores the register defaults (one second timings, no charge limit, a
// repeat count of one). When the receiver stalls, the result is held in the output
// register, the input register fills, and s_axis_tready falls.
`include "assert_macros.svh"

module led_cycle_timer_core
    import lct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // now_ms[31:0], charge_used[63:32]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // led_on[0], phase[3:1], cycles_left[19:4],
                                        // on_time_total_ms[51:20], refused[52], zero[55:53]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic        in_valid_reg;
    logic [1:0]  in_kind_reg;
    logic [31:0] in_now_reg;
    logic [31:0] in_charge_reg;
    logic        out_valid_reg;
    logic [55:0] out_data_reg;
    logic        advance;
    chan_state_t state_reg;
    chan_state_t state_next;
    chan_cfg_t   cfg_reg;
    logic        refused_next;

    // The input register moves into the output register when that is free.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_kind_reg   <= s_axis_tuser;
            in_now_reg    <= s_axis_tdata[31:0];
            in_charge_reg <= s_axis_tdata[63:32];
        end
    end

    // Configuration registers, timings held in milliseconds.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_ms     <= MS_W'(MS_PER_S);
            cfg_reg.on_ms        <= MS_W'(MS_PER_S);
            cfg_reg.off_ms       <= MS_W'(MS_PER_S);
            cfg_reg.charge_limit <= NO_LIMIT;
            cfg_reg.repeat_count <= 16'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_DELAY:
                    cfg_reg.start_ms <= MS_W'(cfg_data[14:0]) * MS_W'(MS_PER_S);
                CFG_ON_TIME:
                    cfg_reg.on_ms <= MS_W'(cfg_data[14:0]) * MS_W'(MS_PER_S);
                CFG_OFF_TIME:
                    cfg_reg.off_ms <= MS_W'(cfg_data[16:0]) * MS_W'(MS_PER_S);
                CFG_CHARGE_LIM:
                    cfg_reg.charge_limit <= cfg_data;
                CFG_REPEAT:
                    cfg_reg.repeat_count <= cfg_data[15:0];
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // Phase sequencer for one word.
    lct_step u_step
    (
        .kind        (in_kind_reg),
        .now_ms      (in_now_reg),
        .charge_used (in_charge_reg),
        .cur         (state_reg),
        .cfg         (cfg_reg),
        .nxt         (state_next),
        .refused     (refused_next)
    );

    // Channel state, updated as each word is committed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {3'b000, refused_next, state_next.on_total,
                             state_next.remaining, state_next.phase, state_next.drive};
        end
    end

    // Checks on the channel state.
    `ASSERT_SAME(a_drive_phase, state_reg.drive,
        (state_reg.phase == PH_ON) || (state_reg.phase == PH_RESET),
        "LED driven outside the on phases")
    `ASSERT_SAME(a_on_drive, state_reg.phase == PH_ON, state_reg.drive,
        "LED not driven in the on phase")
    `ASSERT_SAME(a_stop_active, state_reg.stopping, state_reg.phase != PH_IDLE,
        "stop pending on an idle channel")
    `ASSERT_SAME(a_idle_stamp, state_reg.phase == PH_IDLE, state_reg.phase_stamp == 32'd0,
        "idle channel holds a phase stamp")
    `ASSERT_NEXT(a_hold_state, !advance, $stable(state_reg),
        "channel state changed without a word")
    `ASSERT_NEXT(a_refuse, advance && (in_kind_reg == KIND_RUN) && (state_reg.phase != PH_IDLE),
        m_axis_tdata[52] && $stable(state_reg),
        "run on an active channel not refused")

endmodule
